/* design/lcd_pkg.sv */
// shared types and constants for the lcs line diff block
// no dependencies
package lcd_pkg;

    localparam int MAX_LINES   = 32;
    localparam int TOKEN_BITS  = 32;
    localparam int LINE_W      = $clog2(MAX_LINES + 1);
    localparam int IDX_W       = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int STACK_DEPTH = 2 * MAX_LINES;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int FILL_CYCLES = 2 * MAX_LINES + 4;
    localparam int FILL_W      = $clog2(FILL_CYCLES + 1);
    localparam int ROW_W       = 2 * MAX_LINES;

    typedef enum logic [1:0] {
        OP_LOAD_OLD = 2'd0,
        OP_LOAD_NEW = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2
    } t_kind;

    // backtrack move stored per table entry
    typedef enum logic [1:0] {
        MOVE_DIAG   = 2'd0,
        MOVE_ADD    = 2'd1,
        MOVE_REMOVE = 2'd2
    } t_move;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_BT_READ,
        ST_BT_STEP,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_NONE
    } t_state;

    // what one cell hands to the next each cycle
    typedef struct packed {
        logic                  valid;
        logic [TOKEN_BITS-1:0] tok;
        logic [LINE_W-1:0]     col;
        logic [LINE_W-1:0]     score;
    } t_link;

endpackage

/* design/lcd_ram.sv */
// generic single write port ram with registered read
// no dependencies
module lcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lcd_cell.sv */
// one row of the lcs table: holds one old-file token, scores columns as they pass
// depends on lcd_pkg
module lcd_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_load,
    input  logic [lcd_pkg::TOKEN_BITS-1:0] i_load_tok,
    input  logic [lcd_pkg::LINE_W-1:0]     i_last_col,
    input  lcd_pkg::t_link                 i_link,
    output lcd_pkg::t_link                 o_link,
    output logic                           o_done,
    output logic [lcd_pkg::ROW_W-1:0]      o_row
);
    import lcd_pkg::*;

    logic [TOKEN_BITS-1:0]       r_tok;
    logic [LINE_W-1:0]           r_val;
    logic [LINE_W-1:0]           r_diag;
    logic                        r_valid;
    logic [TOKEN_BITS-1:0]       r_fwd_tok;
    logic [LINE_W-1:0]           r_fwd_col;
    logic                        r_done;
    logic [MAX_LINES-1:0][1:0]   r_row;

    logic                        match;
    logic [LINE_W-1:0]           n_val;
    t_move                       move;

    always_comb begin
        match = (r_tok == i_link.tok);
        if (match) begin
            n_val = r_diag + LINE_W'(1);
            move  = MOVE_DIAG;
        end else if (r_val >= i_link.score) begin
            n_val = r_val;
            move  = MOVE_ADD;
        end else begin
            n_val = i_link.score;
            move  = MOVE_REMOVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_load_tok;
        end
        if (i_link.valid) begin
            r_row[IDX_W'(i_link.col - LINE_W'(1))] <= move;
            r_fwd_tok <= i_link.tok;
            r_fwd_col <= i_link.col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val   <= '0;
            r_diag  <= '0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_clear) begin
            r_val   <= '0;
            r_diag  <= '0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= i_link.valid;
            r_done  <= i_link.valid && (i_link.col == i_last_col);
            if (i_link.valid) begin
                r_val  <= n_val;
                r_diag <= i_link.score;
            end
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.tok   = r_fwd_tok;
    assign o_link.col   = r_fwd_col;
    assign o_link.score = r_val;
    assign o_done       = r_done;
    assign o_row        = r_row;

endmodule

/* design/lcs_line_diff_core.sv */
// top level of the lcs line diff block: stores, cell row, backtrack and output
// depends on lcd_pkg, lcd_cell, lcd_ram
//
// channel | dir | beat contents
// --------+-----+---------------------------------------------------------
// s_axis  | in  | tuser = op, tdata = line_token
// m_axis  | out | tuser = edit_kind, tdata = line_number, common_length,
//         |     | overflowed; tlast = last_edit
//
// load beats are accepted back to back
// a compute beat runs the cell row through the fill, then backtracks with a
// ram row read and a step state per step inside the table, the read state alone
// per step along the top row or left column and a final check, then pops the
// edit stack through a read and a wait state per beat; the input side stays
// stalled until the last result is loaded
// results go through an output register, so downstream stalls only hold the pop
// synchronous active-low reset clears counts, overflow flag and control state
module lcs_line_diff_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] line_token
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] line_number, [11:6] common_length,
                                        // [12] overflowed, [15:13] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] edit_kind
    output logic        m_axis_tlast    // last_edit
);
    import lcd_pkg::*;

    // control registers
    t_state              r_state, n_state;
    logic [LINE_W-1:0]   r_old_cnt, n_old_cnt;
    logic [LINE_W-1:0]   r_new_cnt, n_new_cnt;
    logic                r_ovf, n_ovf;
    logic [FILL_W-1:0]   r_fill_cnt, n_fill_cnt;
    logic                r_feed_valid;
    logic [LINE_W-1:0]   r_feed_col;
    logic [LINE_W-1:0]   r_bi, n_bi;
    logic [LINE_W-1:0]   r_bj, n_bj;
    logic [SP_W-1:0]     r_sp, n_sp;
    logic [LINE_W-1:0]   r_len, n_len;

    // output register
    logic                r_out_valid, n_out_valid;
    t_kind               r_out_kind, n_out_kind;
    logic [LINE_W-1:0]   r_out_num, n_out_num;
    logic [LINE_W-1:0]   r_out_len, n_out_len;
    logic                r_out_ovf, n_out_ovf;
    logic                r_out_last, n_out_last;

    logic                in_fire;
    t_op                 op;
    logic [TOKEN_BITS-1:0] tok;
    logic                out_free;
    logic                start;

    // cell row wiring
    t_link                       link [MAX_LINES+1];
    logic [MAX_LINES-1:0]        done;
    logic [ROW_W-1:0]            rows [MAX_LINES];
    logic [TOKEN_BITS-1:0]       new_rdata;

    // row ram
    logic                        row_we;
    logic [IDX_W-1:0]            row_waddr;
    logic [ROW_W-1:0]            row_wdata;
    logic [ROW_W-1:0]            row_rdata;
    t_move                       cur_move;

    // edit stack
    logic                        push;
    logic [7:0]                  push_data;
    logic [STACK_AW-1:0]         stk_raddr;
    logic [7:0]                  stk_rdata;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign op       = t_op'(s_axis_tuser);
    assign tok      = s_axis_tdata[TOKEN_BITS-1:0];
    assign out_free = !r_out_valid || m_axis_tready;
    assign start    = in_fire && (op == OP_COMPUTE);
    assign s_axis_tready = (r_state == ST_IDLE);

    // new-file store, read in column order during the fill
    lcd_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (MAX_LINES)
    ) u_new_store (
        .i_clk   (i_clk),
        .i_we    (in_fire && (op == OP_LOAD_NEW) && (r_new_cnt < LINE_W'(MAX_LINES))),
        .i_waddr (r_new_cnt[IDX_W-1:0]),
        .i_wdata (tok),
        .i_raddr (r_fill_cnt[IDX_W-1:0]),
        .o_rdata (new_rdata)
    );

    // head of the row: column j enters with an all-zero upper neighbor
    assign link[0].valid = r_feed_valid;
    assign link[0].tok   = new_rdata;
    assign link[0].col   = r_feed_col;
    assign link[0].score = '0;

    for (genvar g = 0; g < MAX_LINES; g++) begin : g_cells
        lcd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (start),
            .i_load     (in_fire && (op == OP_LOAD_OLD) && (r_old_cnt == LINE_W'(g))),
            .i_load_tok (tok),
            .i_last_col (r_new_cnt),
            .i_link     (link[g]),
            .o_link     (link[g+1]),
            .o_done     (done[g]),
            .o_row      (rows[g])
        );
    end

    // cells finish their rows on distinct cycles, so one write port serves all
    always_comb begin
        row_we    = 1'b0;
        row_waddr = '0;
        row_wdata = rows[0];
        for (int k = 0; k < MAX_LINES; k++) begin
            if (done[k]) begin
                row_we    = 1'b1;
                row_waddr = IDX_W'(k);
                row_wdata = rows[k];
            end
        end
    end

    lcd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_LINES)
    ) u_move_table (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (IDX_W'(r_bi - LINE_W'(1))),
        .o_rdata (row_rdata)
    );

    assign cur_move = t_move'(row_rdata[2 * IDX_W'(r_bj - LINE_W'(1)) +: 2]);

    // edits come out of the backtrack in reverse; the stack turns them around
    assign stk_raddr = (r_state == ST_EMIT_RD) ? STACK_AW'(r_sp - SP_W'(1))
                                               : STACK_AW'(r_sp);

    lcd_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_edit_stack (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_sp[STACK_AW-1:0]),
        .i_wdata (push_data),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_old_cnt   = r_old_cnt;
        n_new_cnt   = r_new_cnt;
        n_ovf       = r_ovf;
        n_fill_cnt  = r_fill_cnt;
        n_bi        = r_bi;
        n_bj        = r_bj;
        n_sp        = r_sp;
        n_len       = r_len;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_num   = r_out_num;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        push        = 1'b0;
        push_data   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (op)
                        OP_LOAD_OLD: begin
                            if (r_old_cnt < LINE_W'(MAX_LINES)) begin
                                n_old_cnt = r_old_cnt + LINE_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_LOAD_NEW: begin
                            if (r_new_cnt < LINE_W'(MAX_LINES)) begin
                                n_new_cnt = r_new_cnt + LINE_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_COMPUTE: begin
                            n_fill_cnt = '0;
                            n_state    = ST_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                n_fill_cnt = r_fill_cnt + FILL_W'(1);
                if (r_fill_cnt == FILL_W'(FILL_CYCLES)) begin
                    n_len   = (r_old_cnt == '0) ? '0
                            : link[IDX_W'(r_old_cnt - LINE_W'(1)) + 1].score;
                    n_bi    = r_old_cnt;
                    n_bj    = r_new_cnt;
                    n_sp    = '0;
                    n_state = ST_BT_READ;
                end
            end
            ST_BT_READ: begin
                if (r_bi == '0 && r_bj == '0) begin
                    n_state = (r_sp == '0) ? ST_NONE : ST_EMIT_RD;
                end else if (r_bi == '0) begin
                    push      = 1'b1;
                    push_data = {KIND_ADD, r_bj};
                    n_sp      = r_sp + SP_W'(1);
                    n_bj      = r_bj - LINE_W'(1);
                end else if (r_bj == '0) begin
                    push      = 1'b1;
                    push_data = {KIND_REMOVE, r_bi};
                    n_sp      = r_sp + SP_W'(1);
                    n_bi      = r_bi - LINE_W'(1);
                end else begin
                    n_state = ST_BT_STEP;
                end
            end
            ST_BT_STEP: begin
                n_state = ST_BT_READ;
                case (cur_move)
                    MOVE_DIAG: begin
                        n_bi = r_bi - LINE_W'(1);
                        n_bj = r_bj - LINE_W'(1);
                    end
                    MOVE_ADD: begin
                        push      = 1'b1;
                        push_data = {KIND_ADD, r_bj};
                        n_sp      = r_sp + SP_W'(1);
                        n_bj      = r_bj - LINE_W'(1);
                    end
                    default: begin
                        push      = 1'b1;
                        push_data = {KIND_REMOVE, r_bi};
                        n_sp      = r_sp + SP_W'(1);
                        n_bi      = r_bi - LINE_W'(1);
                    end
                endcase
            end
            ST_EMIT_RD: begin
                n_sp    = r_sp - SP_W'(1);
                n_state = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = t_kind'(stk_rdata[7:6]);
                    n_out_num   = stk_rdata[LINE_W-1:0];
                    n_out_ovf   = r_ovf;
                    n_out_last  = (r_sp == '0);
                    n_out_len   = (r_sp == '0) ? r_len : '0;
                    if (r_sp == '0) begin
                        n_old_cnt = '0;
                        n_new_cnt = '0;
                        n_ovf     = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_NONE;
                    n_out_num   = '0;
                    n_out_len   = r_len;
                    n_out_ovf   = r_ovf;
                    n_out_last  = 1'b1;
                    n_old_cnt   = '0;
                    n_new_cnt   = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_old_cnt    <= '0;
            r_new_cnt    <= '0;
            r_ovf        <= 1'b0;
            r_feed_valid <= 1'b0;
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_old_cnt    <= n_old_cnt;
            r_new_cnt    <= n_new_cnt;
            r_ovf        <= n_ovf;
            r_feed_valid <= (r_state == ST_FILL) && (r_fill_cnt < FILL_W'(r_new_cnt));
            r_sp         <= n_sp;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fill_cnt <= n_fill_cnt;
        r_feed_col <= LINE_W'(r_fill_cnt) + LINE_W'(1);
        r_bi       <= n_bi;
        r_bj       <= n_bj;
        r_len      <= n_len;
        r_out_kind <= n_out_kind;
        r_out_num  <= n_out_num;
        r_out_len  <= n_out_len;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_ovf, r_out_len, r_out_num};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

/* bench/lcs_line_diff_core_test.sv */
// testbench for lcs_line_diff_core: directed and random load/compute streams
// depends on lcd_pkg and the lcs_line_diff_core rtl
module lcs_line_diff_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd_pkg::*;

    // one expected output beat
    typedef struct {
        t_kind          kind;
        logic [5:0]     line_no;
        logic [5:0]     lcs_len;
        logic           ovf;
        logic           last;
    } t_edit;

    // diff predictor plus the queue of expected edit beats
    class diff_scoreboard;
        logic [31:0] old_tok[MAX_LINES];
        logic [31:0] new_tok[MAX_LINES];
        int          old_n;
        int          new_n;
        logic        ovf;
        t_edit       pending[$];
        int          errors;

        function new();
            old_n  = 0;
            new_n  = 0;
            ovf    = 0;
            errors = 0;
        endfunction

        // note one accepted input beat and queue the edits it causes
        function void note_input(t_op op, logic [31:0] tok);
            int    score[MAX_LINES+1][MAX_LINES+1];
            t_kind kinds[$];
            int    nums[$];
            int    i;
            int    j;
            t_edit e;
            case (op)
                OP_LOAD_OLD: begin
                    if (old_n < MAX_LINES) begin
                        old_tok[old_n] = tok;
                        old_n++;
                    end else begin
                        ovf = 1;
                    end
                end
                OP_LOAD_NEW: begin
                    if (new_n < MAX_LINES) begin
                        new_tok[new_n] = tok;
                        new_n++;
                    end else begin
                        ovf = 1;
                    end
                end
                OP_COMPUTE: begin
                    for (i = 0; i <= old_n; i++)
                        for (j = 0; j <= new_n; j++)
                            if (i == 0 || j == 0)
                                score[i][j] = 0;
                            else if (old_tok[i-1] == new_tok[j-1])
                                score[i][j] = score[i-1][j-1] + 1;
                            else
                                score[i][j] = (score[i-1][j] > score[i][j-1]) ?
                                              score[i-1][j] : score[i][j-1];
                    // walk back from the end, ties go to the added line
                    i = old_n;
                    j = new_n;
                    while (i > 0 || j > 0) begin
                        if (i > 0 && j > 0 && old_tok[i-1] == new_tok[j-1]) begin
                            i--;
                            j--;
                        end else if (j > 0 && (i == 0 || score[i][j-1] >= score[i-1][j])) begin
                            kinds.push_front(KIND_ADD);
                            nums.push_front(j);
                            j--;
                        end else begin
                            kinds.push_front(KIND_REMOVE);
                            nums.push_front(i);
                            i--;
                        end
                    end
                    if (kinds.size() == 0) begin
                        kinds.push_back(KIND_NONE);
                        nums.push_back(0);
                    end
                    foreach (kinds[k]) begin
                        e.kind    = kinds[k];
                        e.line_no = 6'(nums[k]);
                        e.last    = (k == kinds.size() - 1);
                        e.lcs_len = e.last ? 6'(score[old_n][new_n]) : 6'd0;
                        e.ovf     = ovf;
                        pending.push_back(e);
                    end
                    old_n = 0;
                    new_n = 0;
                    ovf   = 0;
                end
                default: ;
            endcase
        endfunction

        // compare one accepted output beat with the oldest expectation
        function void check_result(t_kind kind, logic [5:0] line_no, logic [5:0] lcs_len,
                                   logic ovf_bit, logic last);
            t_edit e;
            if (pending.size() == 0) begin
                $error("unexpected edit beat kind=%0d line=%0d", kind, line_no);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind) begin
                $error("edit_kind expected %0d actual %0d", e.kind, kind);
                errors++;
            end
            if (line_no !== e.line_no) begin
                $error("line_number expected %0d actual %0d", e.line_no, line_no);
                errors++;
            end
            if (lcs_len !== e.lcs_len) begin
                $error("common_length expected %0d actual %0d", e.lcs_len, lcs_len);
                errors++;
            end
            if (ovf_bit !== e.ovf) begin
                $error("overflowed expected %0d actual %0d", e.ovf, ovf_bit);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_edit expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;      // [31:0] line_token
    logic [1:0]  s_axis_tuser;      // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;      // [5:0] line_number, [11:6] common_length, [12] overflowed
    logic [1:0]  m_axis_tuser;      // [1:0] edit_kind
    logic        m_axis_tlast;      // last_edit

    diff_scoreboard edits_sb;
    int             beat_gap_left;

    lcs_line_diff_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // output side: check accepted beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            edits_sb.check_result(t_kind'(m_axis_tuser), m_axis_tdata[5:0],
                                  m_axis_tdata[11:6], m_axis_tdata[12], m_axis_tlast);
    end

    // receiver stall pattern: phases of always-ready and random back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if ((($time / 2000) % 3) == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // present one beat, with burst gaps, and hold until it is taken
    task automatic send_beat(t_op op, logic [31:0] tok);
        if (beat_gap_left == 0) begin
            repeat ($urandom_range(0, 4)) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            beat_gap_left = $urandom_range(1, 20);
        end
        beat_gap_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= tok;
        do @(posedge i_clk); while (!s_axis_tready);
        edits_sb.note_input(op, tok);
        @(negedge i_clk);
    endtask

    // one file pair drawn from tokens 0 to alpha, so a small alpha makes matches common
    task automatic send_file_pair(int n_old, int n_new, int alpha);
        int k;
        for (k = 0; k < n_old + n_new; k++) begin
            if ($urandom_range(0, 1) ? (k < n_old) : (k >= n_new))
                send_beat(OP_LOAD_OLD, $urandom_range(0, alpha));
            else
                send_beat(OP_LOAD_NEW, $urandom_range(0, alpha));
        end
        send_beat(OP_COMPUTE, $urandom);
    endtask

    initial begin
        int k;
        edits_sb      = new();
        beat_gap_left = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD_OLD;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty compute, equal files, extreme tokens, pure add/remove, unused op
        send_beat(OP_COMPUTE, 32'h0);
        send_beat(OP_LOAD_OLD, 32'hFFFF_FFFF);
        send_beat(OP_LOAD_NEW, 32'hFFFF_FFFF);
        send_beat(OP_UNUSED, 32'h1234_5678);
        send_beat(OP_COMPUTE, 32'hFFFF_FFFF);
        send_beat(OP_LOAD_NEW, 32'h0);
        send_beat(OP_LOAD_NEW, 32'hAAAA_5555);
        send_beat(OP_COMPUTE, 32'h0);
        send_beat(OP_LOAD_OLD, 32'h5555_AAAA);
        send_beat(OP_LOAD_OLD, 32'h0);
        send_beat(OP_COMPUTE, 32'h0);
        // tie: swapped pair prefers the added line
        send_beat(OP_LOAD_OLD, 32'd1);
        send_beat(OP_LOAD_OLD, 32'd2);
        send_beat(OP_LOAD_NEW, 32'd2);
        send_beat(OP_LOAD_NEW, 32'd1);
        send_beat(OP_COMPUTE, 32'd0);

        // full stores plus overflow on both sides, longest edit script
        for (k = 0; k <= MAX_LINES; k++) begin
            send_beat(OP_LOAD_OLD, 32'h100 + k);
            send_beat(OP_LOAD_NEW, 32'h200 + k);
        end
        send_beat(OP_COMPUTE, 32'h0);

        // random: small file pairs, some noise and unused ops
        for (k = 0; k < 5; k++) begin
            if ($urandom_range(0, 4) == 0)
                send_beat(t_op'($urandom_range(0, 3)), $urandom);
            send_file_pair($urandom_range(0, 6), $urandom_range(0, 6),
                           ($urandom_range(0, 1) ? 3 : 32'hFFFF_FFFF));
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow the output register to settle
        while (edits_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (edits_sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
